// ----- sv/barometric_pressure_compensation_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pressure compensation unit
// Shared property shapes; every macro samples on i_clk and is off in reset.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define BPC_ASSERT_LAT(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, register codes and constants of the pressure compensation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AC_SIGNED   = 3'd0,
        CFG_AC_UNSIGNED = 3'd1,
        CFG_B_PAIR      = 3'd2,
        CFG_MC_MD       = 3'd3,
        CFG_OSS         = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [23:0] raw_press;
    } t_item;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic        [17:0] pressure_pa;
        logic               divide_error;
    } t_result;

    // Divider rows: quotient bits (one cell each) and divisor width.
    localparam int DIV1_Q_W = 27;
    localparam int DIV1_D_W = 19;
    localparam int DIV2_Q_W = 34;
    localparam int DIV2_D_W = 40;
    // Magnitude of the second dividend.
    localparam int MAGD_W   = 63;

    // Cycles from an accepted word to its result strobe.
    localparam int PIPE_LAT = 18 + DIV1_Q_W + DIV2_Q_W;

    localparam int OSS_BASE   = 8;
    localparam int TEMP_ROUND = 8;
    localparam int B6_OFFSET  = 4000;
    localparam int B4_BIAS    = 32768;
    localparam int P_C0       = 3791;

    localparam logic        [15:0] B7_SCALE = 16'd50000;
    localparam logic signed [12:0] P_C2     = 13'sd3038;
    localparam logic signed [13:0] P_C1     = -14'sd7357;

    localparam logic [34:0] P_POS_LIM = 35'h07FFFFFFF;
    localparam logic [34:0] P_NEG_LIM = 35'h080000000;

endpackage

// ----- sv/bpc_div_cell.sv -----
// ----------------------------------------------------------------------------
// bpc_div_cell
// One restoring division step: brings down one dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit in. Registered.
// ----------------------------------------------------------------------------
module bpc_div_cell #(
    parameter int Q_W = 8,
    parameter int D_W = 8,
    parameter int S_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [D_W-1:0] i_rem,
    input  logic [Q_W-1:0] i_nq,
    input  logic [D_W-1:0] i_den,
    input  logic [S_W-1:0] i_side,
    output logic           o_vld,
    output logic [D_W-1:0] o_rem,
    output logic [Q_W-1:0] o_nq,
    output logic [D_W-1:0] o_den,
    output logic [S_W-1:0] o_side
);

    logic [D_W:0]   w_trial;
    logic [D_W:0]   w_diff;
    logic           w_ge;
    logic           r_vld;
    logic [D_W-1:0] r_rem;
    logic [Q_W-1:0] r_nq;
    logic [D_W-1:0] r_den;
    logic [S_W-1:0] r_side;

    assign w_trial = {i_rem, i_nq[Q_W-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_rem  <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
        r_nq   <= {i_nq[Q_W-2:0], w_ge};
        r_den  <= i_den;
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

// ----- sv/bpc_div.sv -----
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned divider: a row of Q_W division cells, one quotient bit
// per cell, with a sideband word carried alongside each dividend.
// ----------------------------------------------------------------------------
module bpc_div #(
    parameter int Q_W = 8,
    parameter int D_W = 8,
    parameter int S_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [D_W-1:0] i_rem,
    input  logic [Q_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    input  logic [S_W-1:0] i_side,
    output logic           o_vld,
    output logic [Q_W-1:0] o_quot,
    output logic [D_W-1:0] o_rem,
    output logic [S_W-1:0] o_side
);

    logic           w_vld  [0:Q_W];
    logic [D_W-1:0] w_rem  [0:Q_W];
    logic [Q_W-1:0] w_nq   [0:Q_W];
    logic [D_W-1:0] w_den  [0:Q_W];
    logic [S_W-1:0] w_side [0:Q_W];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = i_rem;
    assign w_nq[0]   = i_num;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        bpc_div_cell #(
            .Q_W (Q_W),
            .D_W (D_W),
            .S_W (S_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_rem   (w_rem[g]),
            .i_nq    (w_nq[g]),
            .i_den   (w_den[g]),
            .i_side  (w_side[g]),
            .o_vld   (w_vld[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_nq    (w_nq[g+1]),
            .o_den   (w_den[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_vld  = w_vld[Q_W];
    assign o_quot = w_nq[Q_W];
    assign o_rem  = w_rem[Q_W];
    assign o_side = w_side[Q_W];

endmodule

// ----- sv/barometric_pressure_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// Barometric pressure compensation unit
// An accepted word passes through the front stages, the two divider rows
// (27 and 34 cells) and the tail stages before its result strobe.
// Throughput: one word per cycle; busy is high only in reset and the cycle
// after it. Results leave on o_valid and cannot be held off.
// Reset clears the calibration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_unit_macros.svh"

module barometric_pressure_compensation_unit
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_item                 i_item,
    output logic                  o_valid,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int HI_W = MAGD_W - DIV2_Q_W;

    typedef struct packed {
        logic signed [18:0] x1;
        logic        [18:0] up;
        logic               den_zero;
        logic               neg;
    } t_side1;

    typedef struct packed {
        logic signed [15:0] t;
        logic               ovf;
        logic               neg;
        logic               small_b7;
        logic               err;
    } t_side2;

    // Calibration registers
    logic [47:0] r_cal_ac_s;
    logic [47:0] r_cal_ac_u;
    logic [31:0] r_cal_b;
    logic [31:0] r_cal_mcmd;
    logic [1:0]  r_oss;
    logic        r_busy;

    logic signed [15:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic        [15:0] w_ac4, w_ac5, w_ac6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac_s <= '0;
            r_cal_ac_u <= '0;
            r_cal_b    <= '0;
            r_cal_mcmd <= '0;
            r_oss      <= '0;
            r_busy     <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_AC_SIGNED:   r_cal_ac_s <= i_cfg_data;
                    CFG_AC_UNSIGNED: r_cal_ac_u <= i_cfg_data;
                    CFG_B_PAIR:      r_cal_b    <= i_cfg_data[31:0];
                    CFG_MC_MD:       r_cal_mcmd <= i_cfg_data[31:0];
                    CFG_OSS:         r_oss      <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy  = r_busy;
    assign w_ac1 = r_cal_ac_s[47:32];
    assign w_ac2 = r_cal_ac_s[31:16];
    assign w_ac3 = r_cal_ac_s[15:0];
    assign w_ac4 = r_cal_ac_u[47:32];
    assign w_ac5 = r_cal_ac_u[31:16];
    assign w_ac6 = r_cal_ac_u[15:0];
    assign w_b1  = r_cal_b[31:16];
    assign w_b2  = r_cal_b[15:0];
    assign w_mc  = r_cal_mcmd[31:16];
    assign w_md  = r_cal_mcmd[15:0];

    // ---------------- temperature front and first division ----------------
    logic [3:0]  w_up_sh;
    logic [23:0] w_up_full;
    logic        r_s1_vld, r_s2_vld, r_s3_vld;
    logic signed [16:0] r_s1_diff;
    logic        [18:0] r_s1_up, r_s2_up, r_s3_up;
    logic signed [33:0] r_s2_prod;
    logic signed [18:0] w_s3_x1, r_s3_x1;
    logic signed [19:0] w_s3_den, r_s3_den;

    assign w_up_sh   = 4'(OSS_BASE) - {2'b00, r_oss};
    assign w_up_full = i_item.raw_press >> w_up_sh;
    assign w_s3_x1   = r_s2_prod[33:15];
    assign w_s3_den  = {w_s3_x1[18], w_s3_x1} + {{4{w_md[15]}}, w_md};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !r_busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
        r_s1_diff <= $signed({1'b0, i_item.raw_temp}) - $signed({1'b0, w_ac6});
        r_s1_up   <= w_up_full[18:0];
        r_s2_prod <= r_s1_diff * $signed({1'b0, w_ac5});
        r_s2_up   <= r_s1_up;
        r_s3_x1   <= w_s3_x1;
        r_s3_den  <= w_s3_den;
        r_s3_up   <= r_s2_up;
    end

    logic [19:0]         w_den_abs;
    logic [15:0]         w_mc_abs;
    t_side1              w_side1_in, w_side1_out;
    logic                w_d1_vld;
    logic [DIV1_Q_W-1:0] w_d1_quot;

    assign w_den_abs = r_s3_den[19] ? 20'(-r_s3_den) : r_s3_den;
    assign w_mc_abs  = w_mc[15] ? 16'(-w_mc) : w_mc;
    assign w_side1_in.x1       = r_s3_x1;
    assign w_side1_in.up       = r_s3_up;
    assign w_side1_in.den_zero = (r_s3_den == '0);
    assign w_side1_in.neg      = w_mc[15] ^ r_s3_den[19];

    bpc_div #(
        .Q_W (DIV1_Q_W),
        .D_W (DIV1_D_W),
        .S_W ($bits(t_side1))
    ) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s3_vld),
        .i_rem   ('0),
        .i_num   ({w_mc_abs, 11'b0}),
        .i_den   (w_den_abs[DIV1_D_W-1:0]),
        .i_side  (w_side1_in),
        .o_vld   (w_d1_vld),
        .o_quot  (w_d1_quot),
        .o_rem   (),
        .o_side  (w_side1_out)
    );

    // ---------------- B5, B6 and the products behind B3 and B4 ----------------
    logic signed [27:0] w_x2;
    logic signed [28:0] w_b5;
    logic        r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_s8_vld;
    logic        r_s9_vld, r_s10_vld, r_s11_vld, r_s12_vld, r_s13_vld, r_s14_vld;
    logic signed [28:0] r_s4_b5;
    logic        [18:0] r_s4_up, r_s5_up, r_s6_up, r_s7_up, r_s8_up, r_s9_up, r_s10_up;
    logic               r_s4_err, r_s5_err, r_s6_err, r_s7_err, r_s8_err, r_s9_err;
    logic               r_s10_err, r_s11_err, r_s12_err;
    logic signed [15:0] r_s5_t, r_s6_t, r_s7_t, r_s8_t, r_s9_t, r_s10_t, r_s11_t, r_s12_t;
    logic signed [15:0] r_s13_t;
    logic signed [29:0] w_b6, w_t_sum;
    logic signed [25:0] w_t26;
    logic signed [15:0] w_t16;
    logic signed [29:0] r_s5_b6;
    logic signed [59:0] r_s6_b6sq;
    logic signed [45:0] r_s6_ac2b6, r_s6_ac3b6;
    logic signed [41:0] r_s7_sq;
    logic signed [34:0] r_s7_x2a, r_s8_x2a;
    logic signed [32:0] r_s7_x1c, r_s8_x1c;
    logic signed [57:0] r_s8_b2sq, r_s8_b1sq;
    logic signed [47:0] w_x3a, r_s9_x3a;
    logic signed [42:0] w_x3c_sum;
    logic signed [40:0] r_s9_x3c;
    logic signed [48:0] w_b3_base;
    logic        [51:0] w_b3_sh, w_b3_sum;
    logic signed [41:0] w_y;
    logic signed [49:0] r_s10_b3;
    logic signed [41:0] r_s10_y;
    logic signed [58:0] r_s11_b4p;
    logic signed [50:0] r_s11_diff;
    logic        [15:0] w_scale;
    logic signed [39:0] r_s12_b4;
    logic signed [63:0] r_s12_b7;

    assign w_x2 = w_side1_out.neg ? 28'(-{1'b0, w_d1_quot}) : {1'b0, w_d1_quot};
    assign w_b5 = {w_x2[27], w_x2} + {{10{w_side1_out.x1[18]}}, w_side1_out.x1};

    assign w_b6    = {r_s4_b5[28], r_s4_b5} - 30'(B6_OFFSET);
    assign w_t_sum = {r_s4_b5[28], r_s4_b5} + 30'(TEMP_ROUND);
    assign w_t26   = w_t_sum[29:4];

    always_comb begin
        priority if (w_t26[25:15] == {11{w_t26[25]}}) begin
            w_t16 = w_t26[15:0];
        end else if (w_t26[25]) begin
            w_t16 = 16'sh8000;
        end else begin
            w_t16 = 16'sh7FFF;
        end
    end

    assign w_x3a     = {r_s8_b2sq[57], r_s8_b2sq[57:11]} + {{13{r_s8_x2a[34]}}, r_s8_x2a};
    assign w_x3c_sum = {r_s8_b1sq[57], r_s8_b1sq[57:16]} + {{10{r_s8_x1c[32]}}, r_s8_x1c}
                       + 43'd2;
    assign w_b3_base = {r_s9_x3a[47], r_s9_x3a} + {{31{w_ac1[15]}}, w_ac1, 2'b00};
    assign w_b3_sh   = {{3{w_b3_base[48]}}, w_b3_base} << r_oss;
    assign w_b3_sum  = w_b3_sh + 52'd2;
    assign w_y       = {r_s9_x3c[40], r_s9_x3c} + 42'(B4_BIAS);
    assign w_scale   = B7_SCALE >> r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
        end else begin
            r_s4_vld  <= w_d1_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
        end
        r_s4_b5  <= w_b5;
        r_s4_up  <= w_side1_out.up;
        r_s4_err <= w_side1_out.den_zero;

        r_s5_b6  <= w_b6;
        r_s5_t   <= w_t16;
        r_s5_up  <= r_s4_up;
        r_s5_err <= r_s4_err;

        r_s6_b6sq  <= r_s5_b6 * r_s5_b6;
        r_s6_ac2b6 <= w_ac2 * r_s5_b6;
        r_s6_ac3b6 <= w_ac3 * r_s5_b6;
        r_s6_t     <= r_s5_t;
        r_s6_up    <= r_s5_up;
        r_s6_err   <= r_s5_err;

        // B6 squared is never negative and stays below 2^53.
        r_s7_sq  <= {1'b0, r_s6_b6sq[52:12]};
        r_s7_x2a <= r_s6_ac2b6[45:11];
        r_s7_x1c <= r_s6_ac3b6[45:13];
        r_s7_t   <= r_s6_t;
        r_s7_up  <= r_s6_up;
        r_s7_err <= r_s6_err;

        r_s8_b2sq <= w_b2 * r_s7_sq;
        r_s8_b1sq <= w_b1 * r_s7_sq;
        r_s8_x2a  <= r_s7_x2a;
        r_s8_x1c  <= r_s7_x1c;
        r_s8_t    <= r_s7_t;
        r_s8_up   <= r_s7_up;
        r_s8_err  <= r_s7_err;

        r_s9_x3a <= w_x3a;
        r_s9_x3c <= w_x3c_sum[42:2];
        r_s9_t   <= r_s8_t;
        r_s9_up  <= r_s8_up;
        r_s9_err <= r_s8_err;

        r_s10_b3  <= w_b3_sum[51:2];
        r_s10_y   <= w_y;
        r_s10_t   <= r_s9_t;
        r_s10_up  <= r_s9_up;
        r_s10_err <= r_s9_err;

        r_s11_b4p  <= $signed({1'b0, w_ac4}) * r_s10_y;
        r_s11_diff <= {32'b0, r_s10_up} - {r_s10_b3[49], r_s10_b3};
        r_s11_t    <= r_s10_t;
        r_s11_err  <= r_s10_err;

        // B4 fits 40 bits for every calibration word.
        r_s12_b4  <= r_s11_b4p[54:15];
        r_s12_b7  <= r_s11_diff * $signed({1'b0, w_scale});
        r_s12_t   <= r_s11_t;
        r_s12_err <= r_s11_err;
    end

    // ---------------- second division ----------------
    logic                w_small;
    logic [63:0]         w_dvd;
    logic [63:0]         w_dvd_abs;
    logic [39:0]         w_b4_abs;
    logic [MAGD_W-1:0]   r_s13_magd;
    logic [DIV2_D_W-1:0] r_s13_magb;
    logic                r_s13_neg, r_s13_small, r_s13_err;
    logic [DIV2_D_W-1:0] w_hi, r_s14_rem, r_s14_den;
    logic [DIV2_Q_W-1:0] r_s14_num;
    t_side2              r_s14_side, w_side2_out;
    logic                w_d2_vld;
    logic [DIV2_Q_W-1:0] w_d2_quot;

    assign w_small   = (r_s12_b7[63:31] == '0);
    assign w_dvd     = w_small ? {r_s12_b7[62:0], 1'b0} : r_s12_b7;
    assign w_dvd_abs = w_dvd[63] ? 64'(-w_dvd) : w_dvd;
    assign w_b4_abs  = r_s12_b4[39] ? 40'(-r_s12_b4) : r_s12_b4;
    assign w_hi      = {{(DIV2_D_W-HI_W){1'b0}}, r_s13_magd[MAGD_W-1:DIV2_Q_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s13_vld <= 1'b0;
            r_s14_vld <= 1'b0;
        end else begin
            r_s13_vld <= r_s12_vld;
            r_s14_vld <= r_s13_vld;
        end
        r_s13_magd  <= w_dvd_abs[MAGD_W-1:0];
        r_s13_magb  <= w_b4_abs;
        r_s13_neg   <= r_s12_b7[63] ^ r_s12_b4[39];
        r_s13_small <= w_small;
        r_s13_err   <= r_s12_err || (r_s12_b4 == '0);
        r_s13_t     <= r_s12_t;

        // The quotient fits the row exactly when the upper dividend part is
        // below the divisor, which also keeps the starting remainder legal.
        r_s14_rem           <= w_hi;
        r_s14_num           <= r_s13_magd[DIV2_Q_W-1:0];
        r_s14_den           <= r_s13_magb;
        r_s14_side.ovf      <= (w_hi >= r_s13_magb);
        r_s14_side.neg      <= r_s13_neg;
        r_s14_side.small_b7 <= r_s13_small;
        r_s14_side.err      <= r_s13_err;
        r_s14_side.t        <= r_s13_t;
    end

    bpc_div #(
        .Q_W (DIV2_Q_W),
        .D_W (DIV2_D_W),
        .S_W ($bits(t_side2))
    ) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s14_vld),
        .i_rem   (r_s14_rem),
        .i_num   (r_s14_num),
        .i_den   (r_s14_den),
        .i_side  (r_s14_side),
        .o_vld   (w_d2_vld),
        .o_quot  (w_d2_quot),
        .o_rem   (),
        .o_side  (w_side2_out)
    );

    // ---------------- pressure correction ----------------
    logic [34:0]        w_qq;
    logic signed [31:0] w_p;
    logic               r_s15_vld, r_s16_vld, r_s17_vld, r_out_vld;
    logic signed [31:0] r_s15_p, r_s16_p, r_s17_p;
    logic signed [15:0] r_s15_t, r_s16_t, r_s17_t;
    logic               r_s15_err, r_s16_err, r_s17_err;
    logic signed [47:0] r_s16_sqa;
    logic signed [45:0] r_s16_m2, r_s17_m2;
    logic signed [58:0] r_s17_m1;
    logic signed [23:0] w_pa;
    logic signed [43:0] w_corr_sum;
    logic signed [40:0] w_pf;
    logic        [17:0] w_press;
    t_result            r_out;

    assign w_qq = w_side2_out.small_b7 ? {1'b0, w_d2_quot} : {w_d2_quot, 1'b0};

    always_comb begin
        priority if (w_side2_out.ovf) begin
            w_p = w_side2_out.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (w_side2_out.neg) begin
            w_p = (w_qq > P_NEG_LIM) ? 32'sh80000000 : 32'(-w_qq);
        end else begin
            w_p = (w_qq > P_POS_LIM) ? 32'sh7FFFFFFF : w_qq[31:0];
        end
    end

    assign w_pa       = r_s15_p[31:8];
    assign w_corr_sum = {r_s17_m1[58], r_s17_m1[58:16]} + {{14{r_s17_m2[45]}}, r_s17_m2[45:16]}
                        + 44'(P_C0);
    assign w_pf       = {{9{r_s17_p[31]}}, r_s17_p} + {w_corr_sum[43], w_corr_sum[43:4]};

    always_comb begin
        priority if (w_pf[40]) begin
            w_press = '0;
        end else if (w_pf[39:18] != '0) begin
            w_press = '1;
        end else begin
            w_press = w_pf[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s15_vld <= 1'b0;
            r_s16_vld <= 1'b0;
            r_s17_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s15_vld <= w_d2_vld;
            r_s16_vld <= r_s15_vld;
            r_s17_vld <= r_s16_vld;
            r_out_vld <= r_s17_vld;
        end
        r_s15_p   <= w_p;
        r_s15_t   <= w_side2_out.t;
        r_s15_err <= w_side2_out.err;

        r_s16_sqa <= w_pa * w_pa;
        r_s16_m2  <= r_s15_p * P_C1;
        r_s16_p   <= r_s15_p;
        r_s16_t   <= r_s15_t;
        r_s16_err <= r_s15_err;

        r_s17_m1  <= r_s16_sqa * P_C2;
        r_s17_m2  <= r_s16_m2;
        r_s17_p   <= r_s16_p;
        r_s17_t   <= r_s16_t;
        r_s17_err <= r_s16_err;

        r_out.temperature_tenths <= r_s17_err ? 16'sd0 : r_s17_t;
        r_out.pressure_pa        <= r_s17_err ? 18'd0 : w_press;
        r_out.divide_error       <= r_s17_err;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // ---------------- assertions ----------------
    `BPC_ASSERT_LAT(a_word_latency, start && !busy, PIPE_LAT, o_valid, "accepted word gave no result on time")
    `BPC_ASSERT_IMP(a_no_stray_result, o_valid, $past(start && !busy, PIPE_LAT), "result without an accepted word")
    `BPC_ASSERT_IMP(a_error_zeroes, o_valid && o_result.divide_error, (o_result.temperature_tenths == 16'sd0) && (o_result.pressure_pa == 18'd0), "divide error with nonzero result fields")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the barometric pressure compensation unit
// Drives raw temperature and pressure words in random bursts under several
// calibration sets, predicts each compensated word with exact wide integer
// arithmetic, and checks every result strobe in order.
// ----------------------------------------------------------------------------
module testbench
    import bpc_pkg::*;
();

    typedef logic signed [127:0] wide_t;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 i_item;
    logic                  o_valid;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    barometric_pressure_compensation_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the calibration registers.
    logic [47:0] cal_ac_s;
    logic [47:0] cal_ac_u;
    logic [31:0] cal_b;
    logic [31:0] cal_mcmd;
    logic [1:0]  cal_oss;

    t_item   pending_words[$];
    t_result expected_words[$];
    int      error_count;
    int      cycle_count;
    int      burst_left;
    int      gap_left;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic wide_t asr(wide_t v, int n);
        return v >>> n;
    endfunction

    function automatic wide_t clip(wide_t v, wide_t lo, wide_t hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_result compensate(t_item w);
        wide_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        wide_t ut, up, x1, x2, x3, den, b5, b6, b3, b4, b7, p, t, sq, pw, sc;
        t_result r;
        ac1 = wide_t'($signed(cal_ac_s[47:32]));
        ac2 = wide_t'($signed(cal_ac_s[31:16]));
        ac3 = wide_t'($signed(cal_ac_s[15:0]));
        ac4 = wide_t'(cal_ac_u[47:32]);
        ac5 = wide_t'(cal_ac_u[31:16]);
        ac6 = wide_t'(cal_ac_u[15:0]);
        b1  = wide_t'($signed(cal_b[31:16]));
        b2  = wide_t'($signed(cal_b[15:0]));
        mc  = wide_t'($signed(cal_mcmd[31:16]));
        md  = wide_t'($signed(cal_mcmd[15:0]));
        ut  = wide_t'(w.raw_temp);
        up  = wide_t'(w.raw_press >> (8 - cal_oss));
        r   = '0;
        x1  = asr((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) begin
            r.divide_error = 1'b1;
            return r;
        end
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        t  = asr(b5 + 8, 4);
        b6 = b5 - 4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        pw = 1;
        pw = pw << cal_oss;
        b3 = asr((ac1 * 4 + x3) * pw + 2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 2, 2);
        b4 = asr(ac4 * (x3 + 32768), 15);
        if (b4 == 0) begin
            r.divide_error = 1'b1;
            return r;
        end
        sc = 50000 >> cal_oss;
        b7 = (up - b3) * sc;
        if (b7 >= 0 && b7 < wide_t'(64'h80000000))
            p = (b7 * 2) / b4;
        else
            p = (b7 / b4) * 2;
        p  = clip(p, -wide_t'(64'h80000000), wide_t'(64'h7FFFFFFF));
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 3038, 16);
        x2 = asr(-7357 * p, 16);
        p  = p + asr(x1 + x2 + 3791, 4);
        t  = clip(t, -32768, 32767);
        p  = clip(p, 0, 262143);
        r.temperature_tenths = t[15:0];
        r.pressure_pa        = p[17:0];
        return r;
    endfunction

    // Driver: bursts of words separated by random gaps.
    always @(posedge i_clk) begin
        logic  nxt_start;
        t_item nxt_item;
        nxt_start = start;
        nxt_item  = i_item;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!(start && busy)) begin
            if (start)
                expected_words.push_back(compensate(i_item));
            if (gap_left > 0) begin
                gap_left--;
                nxt_start = 1'b0;
            end else if (pending_words.size() > 0) begin
                nxt_start = 1'b1;
                nxt_item  = pending_words.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                nxt_start = 1'b0;
            end
        end
        start  <= nxt_start;
        i_item <= nxt_item;
    end

    // Monitor: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin
        t_result exp_w;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", o_result);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_result.temperature_tenths !== exp_w.temperature_tenths) begin
                    $error("temperature_tenths expected %0d actual %0d",
                           exp_w.temperature_tenths, o_result.temperature_tenths);
                    error_count++;
                end
                if (o_result.pressure_pa !== exp_w.pressure_pa) begin
                    $error("pressure_pa expected %0d actual %0d",
                           exp_w.pressure_pa, o_result.pressure_pa);
                    error_count++;
                end
                if (o_result.divide_error !== exp_w.divide_error) begin
                    $error("divide_error expected %0b actual %0b",
                           exp_w.divide_error, o_result.divide_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_AC_SIGNED:   cal_ac_s = data[47:0];
            CFG_AC_UNSIGNED: cal_ac_u = data[47:0];
            CFG_B_PAIR:      cal_b    = data[31:0];
            CFG_MC_MD:       cal_mcmd = data[31:0];
            default:         cal_oss  = data[1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cal(logic [47:0] acs, logic [47:0] acu, logic [31:0] bp,
                            logic [31:0] mm, logic [1:0] oss);
        write_reg(CFG_AC_SIGNED, acs);
        write_reg(CFG_AC_UNSIGNED, acu);
        write_reg(CFG_B_PAIR, {16'h0, bp});
        write_reg(CFG_MC_MD, {16'h0, mm});
        write_reg(CFG_OSS, {46'h0, oss});
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !start && expected_words.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    function automatic t_item pick_word();
        t_item w;
        w.raw_temp  = 16'($urandom());
        w.raw_press = 24'($urandom());
        // Most words sit near a real sensor reading so the pressure lands in range.
        if ($urandom_range(0, 3) != 0) begin
            w.raw_temp  = 16'($urandom_range(20000, 34000));
            w.raw_press = 24'(($urandom_range(20000, 34000) << 8) | $urandom_range(0, 255));
        end
        return w;
    endfunction

    task automatic run_phase(int count);
        t_item w;
        w = '{raw_temp: 16'h0000, raw_press: 24'h000000};
        pending_words.push_back(w);
        w = '{raw_temp: 16'hFFFF, raw_press: 24'hFFFFFF};
        pending_words.push_back(w);
        w = '{raw_temp: 16'h0000, raw_press: 24'hFFFFFF};
        pending_words.push_back(w);
        w = '{raw_temp: 16'hFFFF, raw_press: 24'h000000};
        pending_words.push_back(w);
        w = '{raw_temp: 16'd27898, raw_press: 24'd23843 << 8};
        pending_words.push_back(w);
        w = '{raw_temp: cal_ac_u[15:0], raw_press: 24'h800000};
        pending_words.push_back(w);
        for (int k = 0; k < count; k++)
            pending_words.push_back(pick_word());
        drain();
    endtask

    initial begin
        logic [47:0] acs_typ;
        logic [47:0] acu_typ;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        gap_left    = 0;
        cal_ac_s    = '0;
        cal_ac_u    = '0;
        cal_b       = '0;
        cal_mcmd    = '0;
        cal_oss     = '0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: every word divides by zero.
        run_phase(40);

        acs_typ = {16'd408, 16'hFFB8, 16'hC7D1};
        acu_typ = {16'd32741, 16'd32757, 16'd23153};
        for (int oss = 0; oss < 4; oss++) begin
            load_cal(acs_typ, acu_typ, {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, oss[1:0]);
            run_phase(140);
        end

        // Denominator X1 + MD of zero at raw_temp == AC6.
        load_cal(acs_typ, acu_typ, {16'd6190, 16'd4}, {16'hDDF9, 16'd0}, 2'd1);
        run_phase(40);

        // Extremes of every calibration field.
        load_cal('1, '1, '1, '1, 2'd3);
        run_phase(60);
        load_cal({3{16'h8000}}, {3{16'h7FFF}}, {2{16'h7FFF}}, {16'h7FFF, 16'h8000}, 2'd0);
        run_phase(60);

        for (int ph = 0; ph < 6; ph++) begin
            load_cal(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                     $urandom(), $urandom(), 2'($urandom()));
            run_phase(70);
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
